>>> hw/rtl/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared widths, codes and controller/datapath handshake types for the
// recent request table.
// ----------------------------------------------------------------------------
package rrt_pkg;

  // default table size
  localparam int unsigned DEF_TABLE_DEPTH = 64;

  // field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned DIGEST_W  = 64;
  localparam int unsigned NONCE_W   = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 7;

  // stream widths
  localparam int unsigned IN_TDATA_W  = DIGEST_W + NONCE_W;
  localparam int unsigned IN_TUSER_W  = FUNC_W;
  localparam int unsigned OUT_FIELD_W = 1 + STATUS_W + OCC_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // one table entry: {expiry, nonce, digest}
  localparam int unsigned WORD_W = TIME_W + NONCE_W + DIGEST_W;

  // configuration reset values
  localparam logic [CFG_W-1:0] LIFETIME_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] PERIOD_RST   = CFG_W'(1000);

  // request kinds
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd1;

  // controller to datapath commands
  typedef struct packed {
    logic capture;       // latch the accepted beat
    logic tick;          // advance time and the sweep countdown
    logic stream_start;  // set up a walk from the table front
    logic scan_run;      // one step of a match walk
    logic sweep_run;     // one step of an expiry walk
    logic record;        // append the held request if allowed
    logic load_out;      // fill the output register
  } rrt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sweep_due;
    logic              scan_done;
    logic              sweep_done;
  } rrt_sts_t;

endpackage

>>> hw/rtl/rrt_ram.sv
// ----------------------------------------------------------------------------
// rrt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/rrt_ctrl.sv
// ----------------------------------------------------------------------------
// rrt_ctrl
// Sequencer for the recent request table: takes one request at a time,
// steps the datapath through match walks, expiry sweeps and appends, and
// owns the output beat valid.
// ----------------------------------------------------------------------------
module rrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output rrt_pkg::rrt_cmd_t cmd_o,
  input  rrt_pkg::rrt_sts_t sts_i
);
  import rrt_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_REC    = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  rrt_cmd_t   cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.func)
          FUNC_TICK: begin
            cmd.tick = 1'b1;
            if (sts_i.sweep_due) begin
              cmd.stream_start = 1'b1;
              state_d          = ST_SWEEP;
            end else begin
              state_d = ST_FINISH;
            end
          end
          FUNC_CHECK, FUNC_RECORD: begin
            cmd.stream_start = 1'b1;
            state_d          = ST_SCAN;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = (sts_i.func == FUNC_RECORD) ? ST_REC : ST_FINISH;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_REC: begin
        cmd.record = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd.sweep_run = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;
  assign cmd_o     = cmd;

endmodule

>>> hw/rtl/rrt_datapath.sv
// ----------------------------------------------------------------------------
// rrt_datapath
// Entry memory, circular buffer pointers, time base, configuration
// registers and the match / expiry checks of the recent request table.
// ----------------------------------------------------------------------------
module rrt_datapath #(
  parameter int unsigned TABLE_DEPTH = rrt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rrt_pkg::FUNC_W-1:0]        func_i,
  input  logic [rrt_pkg::DIGEST_W-1:0]      digest_i,
  input  logic [rrt_pkg::NONCE_W-1:0]       nonce_i,
  input  logic                              cfg_valid_i,
  input  logic [rrt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rrt_pkg::CFG_W-1:0]         cfg_data_i,
  input  rrt_pkg::rrt_cmd_t                 cmd_i,
  output rrt_pkg::rrt_sts_t                 sts_o,
  output logic [rrt_pkg::OUT_TDATA_W-1:0]   out_data_o
);
  import rrt_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned PAD_W = OUT_TDATA_W - OUT_FIELD_W;

  // captured request
  logic [FUNC_W-1:0]   func_q;
  logic [DIGEST_W-1:0] digest_q;
  logic [NONCE_W-1:0]  nonce_q;

  // configuration and time base
  logic [CFG_W-1:0]  lifetime_q, period_q, countdown_q, countdown_d;
  logic [TIME_W-1:0] time_q, time_d;

  // buffer state and walk
  logic [AW-1:0]    front_q, front_d, slot_q, slot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, rem_q, rem_d;
  logic             chk_vld_q, chk_vld_d;
  logic             hit_q, hit_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // memory ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_word, rd_word;
  logic [SUM_W-1:0]  wr_sum;

  logic [DIGEST_W-1:0] rd_digest;
  logic [NONCE_W-1:0]  rd_nonce;
  logic [TIME_W-1:0]   rd_expiry, age;
  logic                match, expired, full;
  logic [AW-1:0]       front_nxt, slot_nxt;
  logic [CNT_W+OCC_W-1:0] cnt_ext;

  rrt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_word),
    .rd_addr_i (slot_q),
    .rd_data_o (rd_word)
  );

  // entry fields and compares
  assign rd_digest = rd_word[DIGEST_W-1:0];
  assign rd_nonce  = rd_word[DIGEST_W +: NONCE_W];
  assign rd_expiry = rd_word[DIGEST_W+NONCE_W +: TIME_W];
  assign match     = (rd_nonce == nonce_q) && (rd_digest == digest_q);
  assign age       = time_q - rd_expiry;
  assign expired   = ~age[TIME_W-1];
  assign full      = (cnt_q == CNT_W'(TABLE_DEPTH));

  // circular pointer increments
  assign front_nxt = (front_q == AW'(TABLE_DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign slot_nxt  = (slot_q == AW'(TABLE_DEPTH - 1)) ? '0 : slot_q + AW'(1);

  // append slot: front + count, wrapped once
  always_comb begin
    wr_sum = SUM_W'(front_q) + SUM_W'(cnt_q);
    if (wr_sum >= SUM_W'(TABLE_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(TABLE_DEPTH);
    end
  end

  assign wr_addr = wr_sum[AW-1:0];
  assign wr_en   = cmd_i.record && !hit_q && !full;
  assign wr_word = {time_q + TIME_W'(lifetime_q), nonce_q, digest_q};

  // time base and sweep countdown
  always_comb begin
    time_d      = time_q;
    countdown_d = countdown_q;
    if (cmd_i.tick) begin
      time_d = time_q + TIME_W'(1);
      if (countdown_q <= CFG_W'(1)) begin
        countdown_d = period_q;
      end else begin
        countdown_d = countdown_q - CFG_W'(1);
      end
    end
    if (cfg_valid_i && (cfg_index_i == CFG_PERIOD)) begin
      countdown_d = cfg_data_i;
    end
  end

  // walk, pop, append
  always_comb begin
    front_d   = front_q;
    cnt_d     = cnt_q;
    slot_d    = slot_q;
    rem_d     = rem_q;
    chk_vld_d = 1'b0;
    hit_d     = hit_q;
    status_d  = status_q;
    if (cmd_i.capture) begin
      hit_d    = 1'b0;
      status_d = STATUS_OK;
    end
    if (cmd_i.stream_start) begin
      slot_d = front_q;
      rem_d  = cnt_q;
    end
    if ((cmd_i.scan_run || cmd_i.sweep_run) && (rem_q != '0)) begin
      slot_d    = slot_nxt;
      rem_d     = rem_q - CNT_W'(1);
      chk_vld_d = 1'b1;
    end
    if (cmd_i.scan_run && chk_vld_q && match) begin
      hit_d = 1'b1;
    end
    if (cmd_i.sweep_run && chk_vld_q && expired) begin
      front_d = front_nxt;
      cnt_d   = cnt_q - CNT_W'(1);
    end
    if (cmd_i.record) begin
      if (hit_q) begin
        status_d = STATUS_DUP;
      end else if (full) begin
        status_d = STATUS_FULL;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q  <= LIFETIME_RST;
      period_q    <= PERIOD_RST;
      countdown_q <= PERIOD_RST;
      time_q      <= '0;
      front_q     <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      status_q    <= STATUS_OK;
    end else begin
      if (cfg_valid_i && (cfg_index_i == CFG_LIFETIME)) begin
        lifetime_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == CFG_PERIOD)) begin
        period_q <= cfg_data_i;
      end
      countdown_q <= countdown_d;
      time_q      <= time_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      status_q    <= status_d;
    end
  end

  // payload registers
  assign cnt_ext = (CNT_W + OCC_W)'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      digest_q <= digest_i;
      nonce_q  <= nonce_i;
    end
    slot_q <= slot_d;
    if (cmd_i.load_out) begin
      out_data_q <= {{PAD_W{1'b0}}, cnt_ext[OCC_W-1:0], status_q, hit_q};
    end
  end

  // status to controller
  assign sts_o.func       = func_q;
  assign sts_o.sweep_due  = (countdown_q <= CFG_W'(1));
  assign sts_o.scan_done  = hit_q || (!chk_vld_q && (rem_q == '0));
  assign sts_o.sweep_done = (chk_vld_q && !expired) || (!chk_vld_q && (rem_q == '0));
  assign out_data_o       = out_data_q;

endmodule

>>> hw/rtl/recent_request_table.sv
// ----------------------------------------------------------------------------
// recent_request_table
// Table of recently satisfied requests with expiry: checks, records and
// time ticks with periodic sweeps of expired entries from the front.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata {nonce, digest}, tuser func
//  m_axis    out        tdata {occupancy, status, seen_before}
//  cfg       in         cfg_index_i register, cfg_data_i value
//
// One request at a time. A check walks the held entries for a match, reading
// the entry memory through its one read port; a match ends the walk early.
// A record adds an append step after that walk. A tick with a sweep pops
// expired entries from the front until it meets a live one or the table is
// empty. A finished result waits in the output register while the next
// request is accepted; the next result then waits in the finish state until
// that register is taken.
// Reset is asynchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module recent_request_table #(
  parameter int unsigned TABLE_DEPTH = rrt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [63:0] name_digest, [95:64] request_nonce
  input  logic [rrt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] func
  input  logic [rrt_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] seen_before, [2:1] status, [9:3] occupancy, [15:10] zero
  output logic [rrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rrt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rrt_pkg::CFG_W-1:0]         cfg_data_i
);
  import rrt_pkg::*;

  rrt_cmd_t cmd;
  rrt_sts_t sts;

  rrt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  rrt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (s_axis_tuser[FUNC_W-1:0]),
    .digest_i    (s_axis_tdata[DIGEST_W-1:0]),
    .nonce_i     (s_axis_tdata[DIGEST_W +: NONCE_W]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

  // registers are always writable
  assign cfg_ready_o = 1'b1;

endmodule

>>> hw/rtl/rrt_checker.sv
// ----------------------------------------------------------------------------
// rrt_checker
// Port-level checks on the recent request table result stream.
// ----------------------------------------------------------------------------
module rrt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import rrt_pkg::*;

  logic                seen;
  logic [STATUS_W-1:0] status;

  assign seen   = m_axis_tdata[0];
  assign status = m_axis_tdata[STATUS_W:1];

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status == STATUS_OK || status == STATUS_DUP ||
                       status == STATUS_FULL))
    else $error("undefined status code");

  // a duplicate report always comes with a match
  a_dup_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == STATUS_DUP) |-> seen)
    else $error("duplicate status without match");

  // a full drop only happens for a new request
  a_full_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == STATUS_FULL) |-> !seen)
    else $error("table full status on a matching request");

  // one request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed under stall");

endmodule

bind recent_request_table rrt_checker u_rrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
